>>> rtl/core/wspl_pkg.sv
`default_nettype none

package wspl_pkg;

   // Widths of the port fields and configuration registers
   localparam int OUT_W      = 24;
   localparam int DRIVE_W    = 2;
   localparam int STICK_W    = 8;
   localparam int PROP_W     = 13;
   localparam int IGAIN_W    = 9;
   localparam int TARGET_W   = 6;
   localparam int LIMIT_W    = 13;
   localparam int LGAIN_W    = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Datapath widths
   localparam int FILT_W  = 34;
   localparam int INTEG_W = 32;
   localparam int ISUM_W  = FILT_W + 2;
   localparam int MUL_A_W = 35;
   localparam int MUL_B_W = 17;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 63;
   localparam int MAG_W   = 31;
   localparam int QUOT_W  = 25;
   localparam int STEP_W  = 4;

   // Fixed-point shifts
   localparam int Q_SHIFT     = 16;
   localparam int RECIP_SHIFT = 37;
   localparam int LOAD_SHIFT  = 8;

   // Filter weights in Q16 (0.84 and 0.16, summing to one)
   localparam logic [MUL_B_W-1:0] K_KEEP = 17'd55050;
   localparam logic [MUL_B_W-1:0] K_NEW  = 17'd10486;

   // ceil(2^37 / 100), split in two 16-bit halves for the shared multiplier
   localparam logic [MUL_B_W-1:0] RECIP_HI = 17'd20971;
   localparam logic [MUL_B_W-1:0] RECIP_LO = 17'd34079;

   // Round half away from zero when dropping the Q16 fraction
   localparam logic signed [PROD_W-1:0] RND_POS = PROD_W'(2 ** (Q_SHIFT - 1));
   localparam logic signed [PROD_W-1:0] RND_NEG = RND_POS - PROD_W'(1);

   // Saturation bounds
   localparam logic signed [ACC_W-1:0] FILT_MAX =
      {{(ACC_W - FILT_W + 1){1'b0}}, {(FILT_W - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] FILT_MIN = ~FILT_MAX;
   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = ~OUT_MAX;
   localparam logic [MAG_W-1:0] OUT_POS_LIM = MAG_W'({(OUT_W - 1){1'b1}});
   localparam logic [MAG_W-1:0] OUT_NEG_LIM = OUT_POS_LIM + MAG_W'(1);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PROP_GAIN      = 3'd0,
      REG_INTEG_GAIN     = 3'd1,
      REG_TARGET_SPEED   = 3'd2,
      REG_INTEGRAL_LIMIT = 3'd3,
      REG_LOAD_MODE      = 3'd4,
      REG_LOAD_GAIN      = 3'd5
   } reg_index_type;

   typedef enum logic [DRIVE_W-1:0] {
      DRIVE_STICK = 2'd0,
      DRIVE_FWD   = 2'd1,
      DRIVE_BACK  = 2'd2
   } drive_mode_type;

   // Microprogram addresses
   typedef enum logic [STEP_W-1:0] {
      S_IDLE       = 4'd0,
      S_FILT_MUL   = 4'd1,
      S_FILT_RND   = 4'd2,
      S_FILT_SUM   = 4'd3,
      S_INTEG      = 4'd4,
      S_PROP_LD    = 4'd5,
      S_TERM_SUM   = 4'd6,
      S_SIGN       = 4'd7,
      S_RECIP_LO   = 4'd8,
      S_RECIP_HI   = 4'd9,
      S_RECIP_SUM  = 4'd10,
      S_QUOT       = 4'd11,
      S_LOAD_MUL   = 4'd12,
      S_LOAD_SCALE = 4'd13,
      S_OUT        = 4'd14
   } step_type;

   typedef enum logic [1:0] {
      A_FILT  = 2'd0,
      A_ERR   = 2'd1,
      A_INTEG = 2'd2,
      A_MAG   = 2'd3
   } a_sel_type;

   typedef enum logic [2:0] {
      B_KEEP  = 3'd0,
      B_NEW   = 3'd1,
      B_PROP  = 3'd2,
      B_IGAIN = 3'd3,
      B_RLO   = 3'd4,
      B_RHI   = 3'd5,
      B_LGAIN = 3'd6
   } b_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD   = 3'd0,
      ACC_ROUND  = 3'd1,
      ACC_LOAD   = 3'd2,
      ACC_ADD    = 3'd3,
      ACC_ADD_HI = 3'd4
   } acc_op_type;

   typedef enum logic [2:0] {
      DST_NONE  = 3'd0,
      DST_FILT  = 3'd1,
      DST_INTEG = 3'd2,
      DST_SIGN  = 3'd3,
      DST_QUOT  = 3'd4,
      DST_SCALE = 3'd5,
      DST_OUT   = 3'd6
   } dst_type;

   typedef enum logic [2:0] {
      J_NEXT      = 3'd0,
      J_WAIT_REQ  = 3'd1,
      J_SKIP_LOAD = 3'd2,
      J_WAIT_RSP  = 3'd3,
      J_GOTO      = 3'd4
   } jump_type;

   // One control word of the microprogram
   typedef struct packed {
      a_sel_type  a_sel;
      b_sel_type  b_sel;
      logic       mul_en;
      acc_op_type acc_op;
      dst_type    dst;
      jump_type   jump;
      step_type   target;
   } uword_type;

   // Conditions the sequencer branches on
   typedef struct packed {
      logic req_valid;
      logic load_mode;
      logic rsp_free;
   } seq_status_type;

endpackage

`default_nettype wire

>>> rtl/core/wspl_if.sv
`default_nettype none

// Input channel: one control tick
interface wspl_req_if import wspl_pkg::*; #(
   parameter int COUNT_BITS = 16
);
   logic                       valid;
   logic                       ready;
   logic signed [COUNT_BITS-1:0] left_count;
   logic signed [COUNT_BITS-1:0] right_count;
   logic [DRIVE_W-1:0]         drive_mode;
   logic signed [STICK_W-1:0]  stick_speed;
   logic                       motor_off;

   modport source (output valid, left_count, right_count, drive_mode, stick_speed,
                   motor_off, input ready);
   modport sink (input valid, left_count, right_count, drive_mode, stick_speed,
                 motor_off, output ready);
endinterface

// Result channel: speed loop drive term
interface wspl_rsp_if import wspl_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [OUT_W-1:0]  speed_drive;

   modport source (output valid, speed_drive, input ready);
   modport sink (input valid, speed_drive, output ready);
endinterface

// Configuration write channel
interface wspl_csr_if import wspl_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

>>> rtl/core/wspl_seq.sv
`default_nettype none

module wspl_seq
   import wspl_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  seq_status_type status,
   output uword_type      uword
);

   step_type step_ff;
   step_type step_in;
   step_type step_next;

   function automatic uword_type uw(a_sel_type a, b_sel_type b, logic m, acc_op_type o,
                                    dst_type d, jump_type j, step_type t);
      return '{a_sel: a, b_sel: b, mul_en: m, acc_op: o, dst: d, jump: j, target: t};
   endfunction

   // Control store
   always_comb begin : control_store
      unique case (step_ff)
         S_IDLE:       uword = uw(A_FILT, B_KEEP, 1'b0, ACC_HOLD, DST_NONE, J_WAIT_REQ, S_IDLE);
         S_FILT_MUL:   uword = uw(A_FILT, B_KEEP, 1'b1, ACC_HOLD, DST_NONE, J_NEXT, S_IDLE);
         S_FILT_RND:   uword = uw(A_ERR, B_NEW, 1'b1, ACC_ROUND, DST_NONE, J_NEXT, S_IDLE);
         S_FILT_SUM:   uword = uw(A_FILT, B_KEEP, 1'b0, ACC_HOLD, DST_FILT, J_NEXT, S_IDLE);
         S_INTEG:      uword = uw(A_FILT, B_PROP, 1'b1, ACC_HOLD, DST_INTEG, J_NEXT, S_IDLE);
         S_PROP_LD:    uword = uw(A_INTEG, B_IGAIN, 1'b1, ACC_LOAD, DST_NONE, J_NEXT, S_IDLE);
         S_TERM_SUM:   uword = uw(A_FILT, B_KEEP, 1'b0, ACC_ADD, DST_NONE, J_NEXT, S_IDLE);
         S_SIGN:       uword = uw(A_FILT, B_KEEP, 1'b0, ACC_HOLD, DST_SIGN, J_NEXT, S_IDLE);
         S_RECIP_LO:   uword = uw(A_MAG, B_RLO, 1'b1, ACC_HOLD, DST_NONE, J_NEXT, S_IDLE);
         S_RECIP_HI:   uword = uw(A_MAG, B_RHI, 1'b1, ACC_LOAD, DST_NONE, J_NEXT, S_IDLE);
         S_RECIP_SUM:  uword = uw(A_MAG, B_KEEP, 1'b0, ACC_ADD_HI, DST_NONE, J_NEXT, S_IDLE);
         S_QUOT:       uword = uw(A_MAG, B_KEEP, 1'b0, ACC_HOLD, DST_QUOT, J_SKIP_LOAD, S_OUT);
         S_LOAD_MUL:   uword = uw(A_MAG, B_LGAIN, 1'b1, ACC_HOLD, DST_NONE, J_NEXT, S_IDLE);
         S_LOAD_SCALE: uword = uw(A_MAG, B_KEEP, 1'b0, ACC_HOLD, DST_SCALE, J_NEXT, S_IDLE);
         S_OUT:        uword = uw(A_MAG, B_KEEP, 1'b0, ACC_HOLD, DST_OUT, J_WAIT_RSP, S_IDLE);
         default:      uword = uw(A_FILT, B_KEEP, 1'b0, ACC_HOLD, DST_NONE, J_GOTO, S_IDLE);
      endcase
   end

   // Branch on the jump field
   always_comb begin : next_step
      step_next = step_type'(STEP_W'(step_ff + 1'b1));
      unique case (uword.jump)
         J_NEXT:      step_in = step_next;
         J_WAIT_REQ:  step_in = status.req_valid ? step_next : step_ff;
         J_SKIP_LOAD: step_in = status.load_mode ? step_next : uword.target;
         J_WAIT_RSP:  step_in = status.rsp_free ? uword.target : step_ff;
         J_GOTO:      step_in = uword.target;
         default:     step_in = S_IDLE;
      endcase
   end

   // Step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/wheel_speed_pi_loop.sv
`default_nettype none

// Speed loop of a balancing robot: each transfer on req_ch is one control tick carrying
// the two wheel counts, drive mode, stick speed and motor-off flag, and yields exactly
// one speed_drive transfer on rsp_ch. The error (minus the count sum) is low-pass
// filtered, folded into a clamped integral, and turned into -(f*kp + I*ki)/100, with
// optional Q8 load gain and 24-bit saturation. A microcoded sequencer steps one shared
// 35x17 multiplier and one accumulator through the tick, skipping the load steps when
// load compensation is off, and returns to its idle step before the next tick is taken;
// the output step stalls while an earlier result has not been taken.
// A finished result waits in the output register while the next tick is accepted.
// Configuration writes are taken in any cycle outside reset and should only be issued
// between ticks.

module wheel_speed_pi_loop
   import wspl_pkg::*;
#(
   parameter int COUNT_BITS = 16
)(
   input  logic       clock,
   input  logic       reset,
   wspl_req_if.sink   req_ch,
   wspl_rsp_if.source rsp_ch,
   wspl_csr_if.sink   csr_ch
);

   localparam int ERR_W = COUNT_BITS + 2;

   uword_type      uword;
   seq_status_type status;

   logic [PROP_W-1:0]   prop_gain_ff, prop_gain_in;
   logic [IGAIN_W-1:0]  integ_gain_ff, integ_gain_in;
   logic [TARGET_W-1:0] target_speed_ff, target_speed_in;
   logic [LIMIT_W-1:0]  integral_limit_ff, integral_limit_in;
   logic                load_mode_ff, load_mode_in;
   logic [LGAIN_W-1:0]  load_gain_ff, load_gain_in;

   logic accept;
   logic rsp_free;
   logic out_write;

   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [STICK_W-1:0] move_ff, move_in;
   logic                      off_ff, off_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [PROD_W-1:0]  rnd_sum;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;

   logic signed [ACC_W-1:0]   fsum;
   logic signed [FILT_W-1:0]  filt_ff, filt_in;
   logic signed [ISUM_W-1:0]  isum;
   logic signed [ISUM_W-1:0]  ilim;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;

   logic [ACC_W-1:0]          tabs;
   logic                      neg_ff, neg_in;
   logic [MAG_W-1:0]          mag_ff, mag_in;

   logic signed [OUT_W-1:0]   out_val;
   logic signed [OUT_W-1:0]   speed_ff, speed_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Sequencer
   assign status = '{req_valid: req_ch.valid, load_mode: load_mode_ff, rsp_free: rsp_free};

   wspl_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .uword  (uword)
   );

   // Handshakes
   assign req_ch.ready = (uword.jump == J_WAIT_REQ) && !reset;
   assign accept       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = !reset;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign out_write    = (uword.dst == DST_OUT) && rsp_free;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.speed_drive = speed_ff;

   // Configuration register writes
   always_comb begin : csr_decode
      prop_gain_in      = prop_gain_ff;
      integ_gain_in     = integ_gain_ff;
      target_speed_in   = target_speed_ff;
      integral_limit_in = integral_limit_ff;
      load_mode_in      = load_mode_ff;
      load_gain_in      = load_gain_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         unique case (reg_index_type'(csr_ch.reg_index))
            REG_PROP_GAIN:      prop_gain_in      = csr_ch.wdata[PROP_W-1:0];
            REG_INTEG_GAIN:     integ_gain_in     = csr_ch.wdata[IGAIN_W-1:0];
            REG_TARGET_SPEED:   target_speed_in   = csr_ch.wdata[TARGET_W-1:0];
            REG_INTEGRAL_LIMIT: integral_limit_in = csr_ch.wdata[LIMIT_W-1:0];
            REG_LOAD_MODE:      load_mode_in      = csr_ch.wdata[0];
            REG_LOAD_GAIN:      load_gain_in      = csr_ch.wdata[LGAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Capture the tick: error, movement term and motor-off flag
   always_comb begin : tick_capture
      err_in  = err_ff;
      move_in = move_ff;
      off_in  = off_ff;
      if (accept) begin
         err_in = -(ERR_W'(req_ch.left_count) + ERR_W'(req_ch.right_count));
         off_in = req_ch.motor_off;
         unique case (drive_mode_type'(req_ch.drive_mode))
            DRIVE_FWD:   move_in = STICK_W'(target_speed_ff);
            DRIVE_BACK:  move_in = -STICK_W'(target_speed_ff);
            DRIVE_STICK: move_in = req_ch.stick_speed;
            default:     move_in = req_ch.stick_speed;
         endcase
      end
   end

   // Shared multiplier operands
   always_comb begin : mul_operands
      unique case (uword.a_sel)
         A_FILT:  mul_a = MUL_A_W'(filt_ff);
         A_ERR:   mul_a = MUL_A_W'(err_ff);
         A_INTEG: mul_a = MUL_A_W'(integ_ff);
         A_MAG:   mul_a = MUL_A_W'(mag_ff);
         default: mul_a = '0;
      endcase
      unique case (uword.b_sel)
         B_KEEP:  mul_b = K_KEEP;
         B_NEW:   mul_b = K_NEW;
         B_PROP:  mul_b = MUL_B_W'(prop_gain_ff);
         B_IGAIN: mul_b = MUL_B_W'(integ_gain_ff);
         B_RLO:   mul_b = RECIP_LO;
         B_RHI:   mul_b = RECIP_HI;
         B_LGAIN: mul_b = MUL_B_W'(load_gain_ff);
         default: mul_b = '0;
      endcase
   end

   assign prod_in = uword.mul_en ? PROD_W'(mul_a) * PROD_W'(mul_b) : prod_ff;

   // Accumulator
   assign rnd_sum = prod_ff + (prod_ff[PROD_W-1] ? RND_NEG : RND_POS);

   always_comb begin : accumulate
      unique case (uword.acc_op)
         ACC_HOLD:   acc_in = acc_ff;
         ACC_ROUND:  acc_in = ACC_W'(rnd_sum >>> Q_SHIFT);
         ACC_LOAD:   acc_in = ACC_W'(prod_ff);
         ACC_ADD:    acc_in = acc_ff + ACC_W'(prod_ff);
         ACC_ADD_HI: acc_in = acc_ff + (ACC_W'(prod_ff) <<< Q_SHIFT);
         default:    acc_in = acc_ff;
      endcase
   end

   // Filter update with 34-bit saturation
   assign fsum = acc_ff + ACC_W'(prod_ff);

   always_comb begin : filter_update
      filt_in = filt_ff;
      if (uword.dst == DST_FILT) begin
         priority if (fsum > FILT_MAX) begin
            filt_in = FILT_W'(FILT_MAX);
         end else if (fsum < FILT_MIN) begin
            filt_in = FILT_W'(FILT_MIN);
         end else begin
            filt_in = FILT_W'(fsum);
         end
      end
   end

   // Integral update with symmetric clamp; clear once the motor-off result is out
   assign isum = ISUM_W'(integ_ff) + ISUM_W'(filt_ff) + (ISUM_W'(move_ff) <<< Q_SHIFT);
   assign ilim = ISUM_W'({integral_limit_ff, {Q_SHIFT{1'b0}}});

   always_comb begin : integral_update
      integ_in = integ_ff;
      if (uword.dst == DST_INTEG) begin
         priority if (isum > ilim) begin
            integ_in = INTEG_W'(ilim);
         end else if (isum < -ilim) begin
            integ_in = INTEG_W'(-ilim);
         end else begin
            integ_in = INTEG_W'(isum);
         end
      end else if (out_write && off_ff) begin
         integ_in = '0;
      end
   end

   // Sign and magnitude of the drive term through division and load scaling
   assign tabs = acc_ff[ACC_W-1] ? -acc_ff : acc_ff;

   always_comb begin : magnitude_update
      neg_in = neg_ff;
      mag_in = mag_ff;
      unique case (uword.dst)
         DST_SIGN: begin
            neg_in = !acc_ff[ACC_W-1] && (acc_ff != '0);
            mag_in = tabs[Q_SHIFT +: MAG_W];
         end
         DST_QUOT:  mag_in = MAG_W'(acc_ff[ACC_W-1:RECIP_SHIFT]);
         DST_SCALE: mag_in = prod_ff[LOAD_SHIFT +: MAG_W];
         default: ;
      endcase
   end

   // Saturate to 24 bits
   always_comb begin : saturate
      if (neg_ff) begin
         out_val = (mag_ff >= OUT_NEG_LIM) ? OUT_MIN : -mag_ff[OUT_W-1:0];
      end else begin
         out_val = (mag_ff > OUT_POS_LIM) ? OUT_MAX : mag_ff[OUT_W-1:0];
      end
   end

   // Output register
   always_comb begin : output_stage
      speed_in     = out_write ? out_val : speed_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_write) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff      <= PROP_W'(6200);
         integ_gain_ff     <= IGAIN_W'(31);
         target_speed_ff   <= TARGET_W'(25);
         integral_limit_ff <= LIMIT_W'(8000);
         load_mode_ff      <= 1'b0;
         load_gain_ff      <= LGAIN_W'(346);
         filt_ff           <= '0;
         integ_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         prop_gain_ff      <= prop_gain_in;
         integ_gain_ff     <= integ_gain_in;
         target_speed_ff   <= target_speed_in;
         integral_limit_ff <= integral_limit_in;
         load_mode_ff      <= load_mode_in;
         load_gain_ff      <= load_gain_in;
         filt_ff           <= filt_in;
         integ_ff          <= integ_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      err_ff   <= err_in;
      move_ff  <= move_in;
      off_ff   <= off_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      speed_ff <= speed_in;
   end

   // Checks
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("sequencer stayed idle after a tick transfer");

   a_motor_off_clears: assert property (@(posedge clock) disable iff (reset)
      (out_write && off_ff) |=> (integ_ff == '0))
      else $error("integral not cleared after motor-off result");

   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      (uword.dst == DST_QUOT) |=> (mag_ff[MAG_W-1:QUOT_W] == '0))
      else $error("reciprocal division produced an out-of-range quotient");

   a_result_from_out_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(out_write))
      else $error("result raised without the output step");

endmodule

`default_nettype wire
